/* hdl/lac_pkg.sv */
package lac_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int PITCH_W        = 13;
	localparam int ADDR_W         = 24;
	localparam int RGB_W          = 24;
	localparam int COLOR_W        = 32;
	localparam int QUEUE_DEPTH    = 2;
	localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd800;
	localparam logic [7:0] CHAN_MAX = 8'hff;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// floor(v / 255), exact for v up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	function automatic logic [7:0] blend_channel(input logic [7:0] src, input logic [7:0] alpha,
			input logic [7:0] acc);
		logic [15:0] p_src;
		logic [15:0] p_acc;
		logic [8:0]  sum;
		p_src = src * alpha;
		p_acc = acc * (CHAN_MAX - alpha);
		sum   = {1'b0, div255(p_src)} + {1'b0, div255(p_acc)};
		return sum[7:0];
	endfunction

endpackage

/* hdl/lac_if.sv */
interface lac_pix_if import lac_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [COORD_BITS-1:0] layer_offset_x;
	logic [COORD_BITS-1:0] layer_offset_y;
	logic [COORD_BITS:0]   layer_length;
	logic [COORD_BITS:0]   layer_height;
	logic [COLOR_W-1:0]    layer_color;
	logic                  layer_visible;
	logic                  last_layer;

	modport source (
		output valid, pixel_x, pixel_y, layer_offset_x, layer_offset_y,
		       layer_length, layer_height, layer_color, layer_visible, last_layer,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, layer_offset_x, layer_offset_y,
		       layer_length, layer_height, layer_color, layer_visible, last_layer,
		output ready
	);
endinterface

interface lac_res_if import lac_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] fb_address;
	logic [RGB_W-1:0]  rgb_color;

	modport source (output valid, fb_address, rgb_color, input ready);
	modport sink   (input valid, fb_address, rgb_color, output ready);
endinterface

/* hdl/layer_alpha_compositor_top.sv */
// Layer alpha compositor. One layer sample per transaction, bottom layer first; the
// transaction flagged last_layer closes the pixel and yields one result (packed RGB and
// framebuffer address pixel_y*pitch+pixel_x, mod 2^24). Sustained rate is one sample per
// clock unless a last sample waits for the sink to take the prior result; blend and address
// math is combinational. Samples enter a two-entry queue and the result sits in an output
// register, so the queue keeps taking samples while a result waits and input stalls only
// once the queue fills; out_ch.valid rises at the edge that pops the last sample. The user
// writes screen_pitch through cfg_we/cfg_wdata only while the block is idle; not enforced.
module layer_alpha_compositor_top import lac_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [PITCH_W-1:0] cfg_wdata,
	lac_pix_if.sink            in_ch,
	lac_res_if.source          out_ch
);

	localparam int ENTRY_W = 2 * COORD_BITS + COLOR_W + 1;

	q_stat_t               q_stat;
	logic                  push;
	logic                  pop;
	logic [COORD_BITS-1:0] f_px;
	logic [COORD_BITS-1:0] f_py;
	logic [COLOR_W-1:0]    f_color;
	logic                  f_last;
	logic [ENTRY_W-1:0]    q_rdata;

	lac_front #(.COORD_BITS(COORD_BITS)) u_front (
		.in_ch  (in_ch),
		.q_stat (q_stat),
		.push   (push),
		.px     (f_px),
		.py     (f_py),
		.color  (f_color),
		.last   (f_last)
	);

	lac_queue #(.DATA_W(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_px, f_py, f_color, f_last}),
		.pop    (pop),
		.rdata  (q_rdata),
		.q_stat (q_stat)
	);

	lac_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.px        (q_rdata[ENTRY_W-1 -: COORD_BITS]),
		.py        (q_rdata[COLOR_W+COORD_BITS -: COORD_BITS]),
		.color     (q_rdata[COLOR_W:1]),
		.last      (q_rdata[0]),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule

/* hdl/lac_front.sv */
module lac_front import lac_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	lac_pix_if.sink               in_ch,
	input  q_stat_t               q_stat,
	output logic                  push,
	output logic [COORD_BITS-1:0] px,
	output logic [COORD_BITS-1:0] py,
	output logic [COLOR_W-1:0]    color,
	output logic                  last
);

	logic [COORD_BITS:0] dx;
	logic [COORD_BITS:0] dy;
	logic                in_x;
	logic                in_y;
	logic                blend;

	assign dx = {1'b0, in_ch.pixel_x} - {1'b0, in_ch.layer_offset_x};
	assign dy = {1'b0, in_ch.pixel_y} - {1'b0, in_ch.layer_offset_y};
	assign in_x = !dx[COORD_BITS] && ({1'b0, dx[COORD_BITS-1:0]} < in_ch.layer_length);
	assign in_y = !dy[COORD_BITS] && ({1'b0, dy[COORD_BITS-1:0]} < in_ch.layer_height);
	assign blend = in_ch.layer_visible && in_x && in_y;

	assign in_ch.ready = !q_stat.full;
	assign push  = in_ch.valid && in_ch.ready;
	assign px    = in_ch.pixel_x;
	assign py    = in_ch.pixel_y;
	// a layer that does not blend goes through with zero alpha, which keeps the accumulator
	assign color = {blend ? in_ch.layer_color[31:24] : 8'd0, in_ch.layer_color[23:0]};
	assign last  = in_ch.last_layer;

endmodule

/* hdl/lac_queue.sv */
module lac_queue import lac_pkg::*; #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output q_stat_t           q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign rdata        = mem_q[rd_ptr_q];
	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == CNT_W'(DEPTH));

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("queue written while full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

endmodule

/* hdl/lac_back.sv */
module lac_back import lac_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [PITCH_W-1:0]    cfg_wdata,
	input  q_stat_t               q_stat,
	input  logic [COORD_BITS-1:0] px,
	input  logic [COORD_BITS-1:0] py,
	input  logic [COLOR_W-1:0]    color,
	input  logic                  last,
	output logic                  pop,
	lac_res_if.source             out_ch
);

	localparam int PROD_W = COORD_BITS + PITCH_W;
	localparam int AW     = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;

	logic [PITCH_W-1:0] pitch_q;
	logic [7:0]         acc_r_q;
	logic [7:0]         acc_g_q;
	logic [7:0]         acc_b_q;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  fb_q;
	logic [RGB_W-1:0]   rgb_q;
	logic [7:0]         r_n;
	logic [7:0]         g_n;
	logic [7:0]         b_n;
	logic [AW-1:0]      addr_full;

	assign r_n = blend_channel(color[23:16], color[31:24], acc_r_q);
	assign g_n = blend_channel(color[15:8], color[31:24], acc_g_q);
	assign b_n = blend_channel(color[7:0], color[31:24], acc_b_q);

	assign addr_full = AW'(py) * AW'(pitch_q) + AW'(px);

	// a layer that is not last needs no room in the output register
	assign pop = !q_stat.empty && (!last || !out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q     <= PITCH_RESET;
			acc_r_q     <= '0;
			acc_g_q     <= '0;
			acc_b_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pitch_q <= cfg_wdata;
			end
			if (pop && last) begin
				acc_r_q <= '0;
				acc_g_q <= '0;
				acc_b_q <= '0;
			end else if (pop) begin
				acc_r_q <= r_n;
				acc_g_q <= g_n;
				acc_b_q <= b_n;
			end
			if (pop && last) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && last) begin
			fb_q  <= addr_full[ADDR_W-1:0];
			rgb_q <= {r_n, g_n, b_n};
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.fb_address = fb_q;
	assign out_ch.rgb_color  = rgb_q;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && last |=> acc_r_q == '0 && acc_g_q == '0 && acc_b_q == '0)
		else $error("accumulator not cleared after last layer");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		pop && last |=> out_valid_q)
		else $error("last layer produced no result");

endmodule

/* dv/tb_layer_alpha_compositor_top.sv */
`timescale 1ns / 100ps

module tb_layer_alpha_compositor_top;
	import lac_pkg::*;

	localparam int CB          = COORD_BITS_DEF;
	localparam int CMAX        = (1 << CB) - 1;
	localparam int SMAX        = 1 << CB;
	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASE_ITEMS = 270;
	localparam int SETTLE_CYC  = 8;

	typedef struct {
		bit [CB-1:0]      px;
		bit [CB-1:0]      py;
		bit [CB-1:0]      ox;
		bit [CB-1:0]      oy;
		bit [CB:0]        len;
		bit [CB:0]        hgt;
		bit [COLOR_W-1:0] color;
		bit               vis;
		bit               last;
	} layer_sample_t;

	typedef struct {
		bit [ADDR_W-1:0] addr;
		bit [RGB_W-1:0]  rgb;
	} pixel_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [PITCH_W-1:0] cfg_wdata;

	lac_pix_if #(.COORD_BITS(CB)) in_ch();
	lac_res_if                    out_ch();

	layer_alpha_compositor_top #(.COORD_BITS(CB)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	layer_sample_t      sample_queue[$];
	pixel_result_t      pixel_expect[$];
	bit [7:0]           acc_red;
	bit [7:0]           acc_grn;
	bit [7:0]           acc_blu;
	bit [PITCH_W-1:0]   pitch_shadow;
	int                 err_cnt;
	int                 idle_cyc;
	int                 cyc;
	int                 send_wait;
	int                 take_wait;
	bit                 in_acc;
	bit                 out_acc;
	bit                 in_quiet;
	bit                 out_quiet;

	always #6 clk = ~clk;

	function automatic bit [7:0] over_chan(bit [7:0] src, bit [7:0] a, bit [7:0] acc);
		int unsigned s;
		s = (int'(src) * int'(a)) / 255 + (int'(acc) * (255 - int'(a))) / 255;
		return s[7:0];
	endfunction

	function automatic bit covers(int p, int off, int size);
		return (p >= off) && (p - off < size);
	endfunction

	function automatic void absorb_sample(layer_sample_t s);
		bit [7:0]      a;
		int unsigned   addr;
		pixel_result_t r;
		a = s.color[31:24];
		if (s.vis && covers(int'(s.px), int'(s.ox), int'(s.len)) &&
				covers(int'(s.py), int'(s.oy), int'(s.hgt))) begin
			acc_red = over_chan(s.color[23:16], a, acc_red);
			acc_grn = over_chan(s.color[15:8], a, acc_grn);
			acc_blu = over_chan(s.color[7:0], a, acc_blu);
		end
		if (s.last) begin
			addr   = int'(s.py) * int'(pitch_shadow) + int'(s.px);
			r.addr = addr[ADDR_W-1:0];
			r.rgb  = {acc_red, acc_grn, acc_blu};
			pixel_expect.push_back(r);
			acc_red = '0;
			acc_grn = '0;
			acc_blu = '0;
		end
	endfunction

	function automatic int draw_gap(bit quiet);
		if (quiet)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic layer_sample_t mk_sample(int px, int py, int ox, int oy, int len,
			int hgt, bit [31:0] color, bit vis, bit last);
		layer_sample_t s;
		s.px    = CB'(px);
		s.py    = CB'(py);
		s.ox    = CB'(ox);
		s.oy    = CB'(oy);
		s.len   = (CB+1)'(len);
		s.hgt   = (CB+1)'(hgt);
		s.color = color;
		s.vis   = vis;
		s.last  = last;
		return s;
	endfunction

	function automatic int pick_coord();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return CMAX;
			default: return $urandom_range(0, CMAX);
		endcase
	endfunction

	function automatic layer_sample_t rand_layer(int px, int py, bit last);
		int        ox;
		int        oy;
		int        len;
		int        hgt;
		int        k;
		bit [31:0] color;
		k   = $urandom_range(0, 9);
		ox  = $urandom_range(0, px);
		oy  = $urandom_range(0, py);
		len = $urandom_range(px - ox + 1, SMAX);
		hgt = $urandom_range(py - oy + 1, SMAX);
		if (k == 6) begin
			len = px - ox + $urandom_range(0, 1);
		end else if (k == 7) begin
			hgt = py - oy + $urandom_range(0, 1);
		end else if (k >= 8) begin
			ox  = $urandom_range(0, CMAX);
			oy  = $urandom_range(0, CMAX);
			len = $urandom_range(0, SMAX);
			hgt = $urandom_range(0, SMAX);
		end
		color = $urandom;
		case ($urandom_range(0, 5))
			0: color[31:24] = 8'h00;
			1: color[31:24] = 8'hff;
			default: ;
		endcase
		return mk_sample(px, py, ox, oy, len, hgt, color, $urandom_range(0, 7) != 0, last);
	endfunction

	function automatic layer_sample_t rand_noise();
		return mk_sample($urandom_range(0, CMAX), $urandom_range(0, CMAX),
			$urandom_range(0, CMAX), $urandom_range(0, CMAX), $urandom_range(0, SMAX),
			$urandom_range(0, SMAX), $urandom, 1'($urandom_range(0, 1)),
			$urandom_range(0, 3) == 0);
	endfunction

	task automatic report(string msg);
		err_cnt++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic queue_phase(int n_items);
		int n;
		int depth;
		int px;
		int py;
		n = 0;
		while (n < n_items) begin
			if ($urandom_range(0, 11) == 0) begin
				sample_queue.push_back(rand_noise());
				n++;
			end else begin
				px    = pick_coord();
				py    = pick_coord();
				depth = $urandom_range(1, 5);
				for (int k = 0; k < depth; k++)
					sample_queue.push_back(rand_layer(px, py, k == depth - 1));
				n += depth;
			end
		end
		sample_queue.push_back(rand_layer(pick_coord(), pick_coord(), 1'b1));
	endtask

	task automatic settle();
		do begin
			@(posedge clk);
			#1;
		end while (sample_queue.size() != 0 || in_ch.valid || pixel_expect.size() != 0);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_pitch(bit [PITCH_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we       <= 1'b0;
		pitch_shadow = v;
	endtask

	// acceptance, scoreboard and watchdog
	always @(posedge clk) begin : mon
		layer_sample_t s;
		pixel_result_t r;
		in_acc  = arst_n && in_ch.valid && in_ch.ready;
		out_acc = arst_n && out_ch.valid && out_ch.ready;
		cyc++;
		if (cyc % 150 == 0) begin
			in_quiet  = ($urandom_range(0, 3) == 0);
			out_quiet = ($urandom_range(0, 3) == 0);
		end
		if (in_acc) begin
			s.px    = in_ch.pixel_x;
			s.py    = in_ch.pixel_y;
			s.ox    = in_ch.layer_offset_x;
			s.oy    = in_ch.layer_offset_y;
			s.len   = in_ch.layer_length;
			s.hgt   = in_ch.layer_height;
			s.color = in_ch.layer_color;
			s.vis   = in_ch.layer_visible;
			s.last  = in_ch.last_layer;
			absorb_sample(s);
		end
		if (out_acc) begin
			if (pixel_expect.size() == 0) begin
				report($sformatf("unexpected result addr %06h rgb %06h",
					out_ch.fb_address, out_ch.rgb_color));
			end else begin
				r = pixel_expect.pop_front();
				if (out_ch.fb_address !== r.addr)
					report($sformatf("fb_address got %06h exp %06h", out_ch.fb_address, r.addr));
				if (out_ch.rgb_color !== r.rgb)
					report($sformatf("rgb_color got %06h exp %06h", out_ch.rgb_color, r.rgb));
			end
		end
		if (arst_n) begin
			if (in_acc || out_acc)
				idle_cyc = 0;
			else
				idle_cyc++;
			if (idle_cyc >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// sample driver
	always @(negedge clk) begin : drv
		layer_sample_t s;
		if (arst_n && !(in_ch.valid && !in_acc)) begin
			if (send_wait > 0) begin
				in_ch.valid <= 1'b0;
				send_wait--;
			end else if (sample_queue.size() != 0) begin
				s = sample_queue.pop_front();
				in_ch.pixel_x        <= s.px;
				in_ch.pixel_y        <= s.py;
				in_ch.layer_offset_x <= s.ox;
				in_ch.layer_offset_y <= s.oy;
				in_ch.layer_length   <= s.len;
				in_ch.layer_height   <= s.hgt;
				in_ch.layer_color    <= s.color;
				in_ch.layer_visible  <= s.vis;
				in_ch.last_layer     <= s.last;
				in_ch.valid          <= 1'b1;
				send_wait = draw_gap(in_quiet);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result sink back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_acc)
				take_wait = draw_gap(out_quiet);
			if (take_wait > 0) begin
				out_ch.ready <= 1'b0;
				take_wait--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int pitch_plan[$];
		clk                  = 1'b0;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		in_ch.valid          = 1'b0;
		in_ch.pixel_x        = '0;
		in_ch.pixel_y        = '0;
		in_ch.layer_offset_x = '0;
		in_ch.layer_offset_y = '0;
		in_ch.layer_length   = '0;
		in_ch.layer_height   = '0;
		in_ch.layer_color    = '0;
		in_ch.layer_visible  = 1'b0;
		in_ch.last_layer     = 1'b0;
		out_ch.ready         = 1'b0;
		pitch_shadow         = PITCH_RESET;
		acc_red              = '0;
		acc_grn              = '0;
		acc_blu              = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, coverage edges, alpha extremes, an invisible layer
		sample_queue.push_back(mk_sample(0, 0, 0, 0, SMAX, SMAX, 32'hffffffff, 1, 1));
		sample_queue.push_back(mk_sample(CMAX, CMAX, CMAX, CMAX, 1, 1, 32'h80c04020, 1, 1));
		sample_queue.push_back(mk_sample(10, 20, 0, 0, 100, 100, 32'hffff0000, 1, 0));
		sample_queue.push_back(mk_sample(10, 20, 0, 0, 100, 100, 32'h0000ff00, 1, 0));
		sample_queue.push_back(mk_sample(10, 20, 5, 5, 6, 16, 32'h800000ff, 1, 1));
		sample_queue.push_back(mk_sample(7, 7, 0, 0, 0, 50, 32'hff123456, 1, 1));
		sample_queue.push_back(mk_sample(7, 7, 0, 0, 50, 0, 32'hff123456, 1, 1));
		sample_queue.push_back(mk_sample(3, 9, 4, 0, 100, 100, 32'hff654321, 1, 1));
		sample_queue.push_back(mk_sample(9, 3, 0, 4, 100, 100, 32'hff654321, 1, 1));
		sample_queue.push_back(mk_sample(100, 50, 40, 0, 60, SMAX, 32'hffaaaaaa, 1, 1));
		sample_queue.push_back(mk_sample(50, 100, 0, 40, SMAX, 60, 32'hffaaaaaa, 1, 1));
		sample_queue.push_back(mk_sample(100, 50, 40, 0, 61, SMAX, 32'hffaaaaaa, 1, 1));
		sample_queue.push_back(mk_sample(1, 1, 0, 0, 2, 2, 32'hff00ff00, 1, 0));
		sample_queue.push_back(mk_sample(1, 1, 0, 0, 2, 2, 32'hffffffff, 0, 1));
		sample_queue.push_back(mk_sample(2, 2, 0, 0, SMAX, SMAX, 32'h7f102030, 1, 0));
		sample_queue.push_back(mk_sample(2, 2, 0, 0, SMAX, SMAX, 32'hffabcdef, 1, 1));
		sample_queue.push_back(mk_sample(CMAX, 0, 0, 0, SMAX, SMAX, 32'hc0ffffff, 1, 1));
		sample_queue.push_back(mk_sample(0, CMAX, 0, CMAX, SMAX, SMAX, 32'h01ffffff, 1, 1));
		sample_queue.push_back(mk_sample(CMAX, CMAX, 1, 1, SMAX, SMAX, 32'h55ffffff, 1, 0));
		sample_queue.push_back(mk_sample(CMAX, CMAX, 0, 0, SMAX, SMAX, 32'haa000000, 1, 0));
		sample_queue.push_back(mk_sample(CMAX, CMAX, CMAX, CMAX, SMAX, SMAX, 32'h33f0f0f0,
			1, 1));
		settle();

		pitch_plan = '{1, 4096, 0, 8191, 1, 800, 1};
		pitch_plan[4] = $urandom_range(1, 4096);
		pitch_plan[6] = $urandom_range(0, 8191);
		foreach (pitch_plan[i]) begin
			write_pitch(PITCH_W'(pitch_plan[i]));
			sample_queue.push_back(mk_sample(CMAX, CMAX, 0, 0, SMAX, SMAX, 32'hff808080,
				1, 1));
			queue_phase(PHASE_ITEMS);
			settle();
		end

		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
hdl/lac_pkg.sv
hdl/lac_if.sv
hdl/lac_front.sv
hdl/lac_queue.sv
hdl/lac_back.sv
hdl/layer_alpha_compositor_top.sv
dv/tb_layer_alpha_compositor_top.sv
